@@ hw/rtl/irp_pkg.sv @@
// Shared types and constants of the flow record packer.
// No dependencies; every module of the block imports this package.
`default_nettype none
package irp_pkg;
    localparam int BUF_BYTES_DEF = 512;
    localparam int POS_W         = 10;
    localparam int HDR_BYTES     = 16;
    localparam int SET_HDR_BYTES = 4;
    localparam int SIZE_V4       = 29;
    localparam int SIZE_V6       = 41;
    localparam int SIZE_VNI      = 33;
    localparam int REC_W         = 328;
    localparam int STREAM_W      = 360;
    localparam int LEN_W         = 6;
    localparam logic [15:0] IPFIX_VERSION = 16'h000a;

    typedef enum logic [1:0] {OP_V4, OP_V6, OP_VNI, OP_FLUSH} t_op;
    typedef enum logic [1:0] {KIND_NONE, KIND_V4, KIND_V6, KIND_VNI} t_kind;
    typedef enum logic [0:0] {REG_DOMAIN, REG_REGION} t_reg;
    typedef enum logic [2:0] {ST_IDLE, ST_PATCH, ST_READ, ST_SEND, ST_WRITE} t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] segment_id;
        logic [31:0] dst_region;
        logic [63:0] packet_count;
        logic [63:0] byte_count;
        logic [7:0]  direction;
        logic [31:0] stamp_secs;
    } t_in;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } t_out;

    typedef struct packed {
        logic                has_patch;
        logic [POS_W-1:0]    patch_pos;
        logic [15:0]         patch_val;
        logic                has_emit;
        logic [POS_W-1:0]    emit_len;
        logic [31:0]         emit_seq;
        logic [31:0]         emit_time;
        logic                has_write;
        logic [POS_W-1:0]    wr_pos;
        logic [LEN_W-1:0]    wr_len;
        logic [STREAM_W-1:0] wr_bytes;
    } t_job;
endpackage
`default_nettype wire

@@ hw/rtl/irp_front.sv @@
// Front end: accepts records and flushes, tracks fill and open set, builds jobs.
// Depends on irp_pkg.
`default_nettype none
module irp_front #(
    parameter int BUF_BYTES = irp_pkg::BUF_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire irp_pkg::t_in  i_in,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [31:0]   i_local_region,
    input  wire logic          i_full,
    output logic               o_push,
    output irp_pkg::t_job      o_job
);
    import irp_pkg::*;

    localparam logic [POS_W:0] BUF_L = (POS_W+1)'(BUF_BYTES);

    logic [POS_W-1:0] r_fill, r_off;
    t_kind            r_kind;
    logic [31:0]      r_recs, r_first;

    t_op              op;
    t_kind            kind_new;
    logic [POS_W-1:0] size, base;
    logic [POS_W:0]   sum_same, sum_new;
    logic             accept, same, open_new, do_emit, flush_live;
    logic [REC_W-1:0] rec;
    logic [15:0]      tmpl;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        op = t_op'(i_in.operation);
        unique case (op)
            OP_V4: begin
                size = POS_W'(SIZE_V4);   kind_new = KIND_V4;
                rec  = {i_in.addr_low[31:0], i_in.dst_region, i_in.packet_count,
                        i_in.byte_count, i_in.direction, 16'h0, i_local_region[15:0], 96'h0};
            end
            OP_V6: begin
                size = POS_W'(SIZE_V6);   kind_new = KIND_V6;
                rec  = {i_in.addr_high, i_in.addr_low, i_in.dst_region, i_in.packet_count,
                        i_in.byte_count, i_in.direction, 16'h0, i_local_region[15:0]};
            end
            OP_VNI: begin
                size = POS_W'(SIZE_VNI);  kind_new = KIND_VNI;
                rec  = {32'h0, i_in.segment_id, i_in.packet_count, i_in.byte_count,
                        i_in.direction, i_local_region, i_in.dst_region, 64'h0};
            end
            default: begin
                size = '0;                kind_new = KIND_NONE;
                rec  = '0;
            end
        endcase
        tmpl       = {8'h01, 6'h0, i_in.operation};
        sum_same   = {1'b0, r_fill} + {1'b0, size};
        sum_new    = sum_same + (POS_W+1)'(SET_HDR_BYTES);
        same       = (r_kind == kind_new) && (sum_same <= BUF_L);
        open_new   = !same;
        flush_live = r_fill > POS_W'(HDR_BYTES);
        do_emit    = (op == OP_FLUSH) ? flush_live
                                      : (open_new && (sum_new > BUF_L) && flush_live);
        base       = do_emit ? POS_W'(HDR_BYTES) : r_fill;

        o_job.has_patch = (r_kind != KIND_NONE) && ((op == OP_FLUSH) || open_new);
        o_job.patch_pos = r_off + POS_W'(2);
        o_job.patch_val = 16'(r_fill - r_off);
        o_job.has_emit  = do_emit;
        o_job.emit_len  = r_fill;
        o_job.emit_seq  = r_first;
        o_job.emit_time = i_in.stamp_secs;
        o_job.has_write = (op != OP_FLUSH);
        o_job.wr_pos    = base;
        o_job.wr_len    = LEN_W'(size + (open_new ? POS_W'(SET_HDR_BYTES) : '0));
        o_job.wr_bytes  = open_new ? {tmpl, 16'h0, rec} : {rec, 32'h0};
        // drop a flush that finds nothing packed
        o_push = accept && ((op != OP_FLUSH) || flush_live);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= POS_W'(HDR_BYTES);
            r_off   <= '0;
            r_kind  <= KIND_NONE;
            r_recs  <= '0;
            r_first <= '0;
        end else if (o_push) begin
            if (do_emit) r_first <= r_recs;
            if (op == OP_FLUSH) begin
                r_fill <= POS_W'(HDR_BYTES);
                r_kind <= KIND_NONE;
            end else begin
                r_recs <= r_recs + 32'd1;
                if (open_new) begin
                    r_off  <= base;
                    r_kind <= kind_new;
                    r_fill <= base + POS_W'(SET_HDR_BYTES) + size;
                end else begin
                    r_fill <= r_fill + size;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/irp_queue.sv @@
// Two-entry job queue between front end and back end.
// Depends on irp_pkg.
`default_nettype none
module irp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire irp_pkg::t_job  i_job,
    output logic                o_full,
    output logic                o_nonempty,
    input  wire logic           i_pop,
    output irp_pkg::t_job       o_job
);
    import irp_pkg::*;

    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full     = r_cnt == 2'd2;
    assign o_nonempty = r_cnt != 2'd0;
    assign o_job      = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/irp_back.sv @@
// Back end: writes record bytes into the lane-split store, patches set lengths
// and streams finished messages out. Depends on irp_pkg.
`default_nettype none
module irp_back #(
    parameter int BUF_BYTES = irp_pkg::BUF_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire irp_pkg::t_job  i_job,
    input  wire logic           i_job_valid,
    output logic                o_pop,
    input  wire logic [31:0]    i_domain,
    output irp_pkg::t_out       o_out,
    output logic                o_out_valid,
    input  wire logic           i_out_ready
);
    import irp_pkg::*;

    localparam int ROWS = (BUF_BYTES + 7) / 8;
    localparam int RW   = $clog2(ROWS);

    t_state             r_state, n_state;
    t_job               r_job;
    logic [POS_W-4:0]   r_word;
    logic [2:0]         r_chunk;
    t_out               r_out;
    logic               r_out_valid;

    logic               wr_en, rd_en, load_out;
    logic [POS_W-1:0]   wr_q, len_m1, rem;
    logic [63:0]        wr_data, rd_word, raw;
    logic [3:0]         wr_cnt, vb;
    logic [LEN_W-1:0]   chunk_rem;
    logic               last, chunk_done;
    logic [7:0]         rd_lane [8];
    logic [STREAM_W+23:0] wr_stream;

    always_comb begin
        chunk_rem  = r_job.wr_len - LEN_W'({r_chunk, 3'b000});
        chunk_done = chunk_rem <= LEN_W'(8);
        len_m1     = r_job.emit_len - POS_W'(1);
        last       = r_word == len_m1[POS_W-1:3];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_job_valid) begin
                n_state = i_job.has_patch ? ST_PATCH :
                          i_job.has_emit  ? ST_READ  :
                          i_job.has_write ? ST_WRITE : ST_IDLE;
            end
            ST_PATCH: n_state = r_job.has_emit  ? ST_READ  :
                                r_job.has_write ? ST_WRITE : ST_IDLE;
            ST_READ:  n_state = ST_SEND;
            ST_SEND: if (!r_out_valid || i_out_ready) begin
                n_state = !last ? ST_READ : r_job.has_write ? ST_WRITE : ST_IDLE;
            end
            ST_WRITE: if (chunk_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == ST_IDLE) && i_job_valid;
        rd_en    = r_state == ST_READ;
        load_out = (r_state == ST_SEND) && (!r_out_valid || i_out_ready);
        wr_en    = (r_state == ST_PATCH) || (r_state == ST_WRITE);
        // pad the stream so the last 8-byte chunk stays in range
        wr_stream = {r_job.wr_bytes, 24'h0};
        if (r_state == ST_PATCH) begin
            wr_q    = r_job.patch_pos;
            wr_data = {r_job.patch_val, 48'h0};
            wr_cnt  = 4'd2;
        end else begin
            wr_q    = r_job.wr_pos + POS_W'({r_chunk, 3'b000});
            wr_data = wr_stream[STREAM_W+23 - 64*r_chunk -: 64];
            wr_cnt  = chunk_done ? 4'(chunk_rem) : 4'd8;
        end
    end

    // one memory per byte lane; an unaligned 8-byte beat hits each lane once
    for (genvar l = 0; l < 8; l++) begin : g_lane
        logic [7:0]     r_mem [ROWS];
        logic [7:0]     r_rd;
        logic [2:0]     idx;
        logic [POS_W-4:0] row_full;
        logic [RW-1:0]  wrow;
        logic           we;
        logic [63:0]    sh;

        always_comb begin
            idx      = 3'(l) - wr_q[2:0];
            row_full = wr_q[POS_W-1:3] + (POS_W-3)'(3'(l) < wr_q[2:0]);
            wrow     = row_full[RW-1:0];
            we       = wr_en && ({1'b0, idx} < wr_cnt);
            sh       = wr_data >> (8 * (7 - idx));
        end

        always_ff @(posedge i_clk) begin
            if (we)    r_mem[wrow] <= sh[7:0];
            if (rd_en) r_rd <= r_mem[r_word[RW-1:0]];
        end
        assign rd_lane[l] = r_rd;
    end

    always_comb begin
        rd_word = {rd_lane[0], rd_lane[1], rd_lane[2], rd_lane[3],
                   rd_lane[4], rd_lane[5], rd_lane[6], rd_lane[7]};
        rem = r_job.emit_len - POS_W'({r_word, 3'b000});
        vb  = (rem >= POS_W'(8)) ? 4'd8 : 4'(rem);
        // header words come from the job and the domain register, not the store
        if (r_word == '0)
            raw = {IPFIX_VERSION, 16'(r_job.emit_len), r_job.emit_time};
        else if (r_word == (POS_W-3)'(1))
            raw = {r_job.emit_seq, i_domain};
        else
            raw = rd_word;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) >= vb) raw[63-8*b -: 8] = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (load_out) begin
            r_out.message_word <= raw;
            r_out.valid_bytes  <= vb;
            r_out.last_word    <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_word      <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_word  <= '0;
                r_chunk <= '0;
            end
            if (load_out && !last) r_word <= r_word + (POS_W-3)'(1);
            if (r_state == ST_WRITE) r_chunk <= r_chunk + 3'd1;
            if (load_out)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last_word |-> o_out.valid_bytes == 4'd8)
        else $error("short word before end of message");
    a_vb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.valid_bytes != 4'd0) && (o_out.valid_bytes <= 4'd8))
        else $error("valid_bytes out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_pop)
        else $error("job taken while busy");
endmodule
`default_nettype wire

@@ hw/rtl/ipfix_record_packer_unit.sv @@
// Flow record packer top level: configuration registers, front end, job queue
// and back end. Depends on irp_pkg, irp_front, irp_queue, irp_back.
//
// Input channel (i_in_valid/o_in_ready, payload i_in) takes one IPv4, IPv6 or
// VNI flow record, or a flush, per beat. The front end classifies the beat
// combinationally and queues a job; a flush with nothing packed is dropped.
// The back end runs one job at a time: it takes the job, patches a closing set
// length, then for each output beat of a message reads the store and loads the
// output register, then writes the record in 8-byte chunks (four to six).
// Output channel (o_out_valid/i_out_ready, payload o_out) carries 64-bit
// message beats; a stalled receiver holds the back end, and the two-entry
// queue then fills and drops o_in_ready.
// Configuration channel is always ready; write it only while idle.
// Reset (i_rst_n low, synchronous) empties the queue and output, clears the
// counters and registers, and leaves the header space reserved.
`default_nettype none
module ipfix_record_packer_unit #(
    parameter int BUF_BYTES = irp_pkg::BUF_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire irp_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output irp_pkg::t_out      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire irp_pkg::t_reg i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    import irp_pkg::*;

    logic [31:0] r_domain, r_region;
    logic        push, full, nonempty, pop;
    t_job        job_in, job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain <= '0;
            r_region <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DOMAIN: r_domain <= i_cfg_data;
                REG_REGION: r_region <= i_cfg_data;
                default: ;
            endcase
        end
    end

    irp_front #(.BUF_BYTES(BUF_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_in, .i_in_valid, .o_in_ready,
        .i_local_region(r_region), .i_full(full), .o_push(push), .o_job(job_in)
    );

    irp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job_in), .o_full(full),
        .o_nonempty(nonempty), .i_pop(pop), .o_job(job_out)
    );

    irp_back #(.BUF_BYTES(BUF_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_job(job_out), .i_job_valid(nonempty), .o_pop(pop),
        .i_domain(r_domain), .o_out, .o_out_valid, .i_out_ready
    );
endmodule
`default_nettype wire
